// File: hw/rtl/jcws_pkg.sv
// Shared types and constants for the JSON comment and whitespace stripper.
package jcws_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_STRING     = 3'd5,
    MODE_STRING_ESC = 3'd6
  } scan_mode_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_item_t;

endpackage

// File: hw/rtl/json_comment_whitespace_stripper_top.sv
// Top level of the JSON comment and whitespace stripper.
// Minifies a JSON text, one byte per item: outside strings, whitespace, line
// comments, block comments and stray slashes are dropped; inside strings every
// byte is kept, backslash escapes included. Each input item yields zero or one
// result item in the cycle after acceptance; an item with in_last set always yields
// a result with out_last set (byte_valid 0 if that byte was dropped) and resets
// the scanner to normal mode. One item per cycle is sustained while out_ready
// holds: the scan mode update is a small next-state function between the input
// handshake and a single output register, and input is taken whenever that
// register is empty or being drained in the same cycle.
module json_comment_whitespace_stripper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jcws_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jcws_pkg::out_item_t out_data
);

  jcws_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic                 keep;
  logic                 plain_keep;
  jcws_pkg::scan_mode_t plain_mode;
  logic [7:0]           b;
  logic                 accept;
  logic                 emit;

  assign b        = in_data.in_byte;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = keep || in_data.in_last;

  // Handling of a byte outside strings and comments.
  always_comb begin
    plain_keep = 1'b1;
    plain_mode = jcws_pkg::MODE_NORMAL;
    if (b == jcws_pkg::CH_SPACE || b == jcws_pkg::CH_TAB ||
        b == jcws_pkg::CH_CR || b == jcws_pkg::CH_LF) begin
      plain_keep = 1'b0;
    end else if (b == jcws_pkg::CH_SLASH) begin
      plain_keep = 1'b0;
      plain_mode = jcws_pkg::MODE_SLASH;
    end else if (b == jcws_pkg::CH_QUOTE) begin
      plain_mode = jcws_pkg::MODE_STRING;
    end
  end

  // Next-state function.
  always_comb begin
    scan_mode_next = jcws_pkg::MODE_NORMAL;
    unique case (scan_mode)
      jcws_pkg::MODE_SLASH: begin
        if (b == jcws_pkg::CH_SLASH) scan_mode_next = jcws_pkg::MODE_LINE;
        else if (b == jcws_pkg::CH_STAR) scan_mode_next = jcws_pkg::MODE_BLOCK;
        else scan_mode_next = plain_mode;
      end
      jcws_pkg::MODE_LINE: begin
        scan_mode_next = (b == jcws_pkg::CH_LF) ? jcws_pkg::MODE_NORMAL
                                                : jcws_pkg::MODE_LINE;
      end
      jcws_pkg::MODE_BLOCK: begin
        scan_mode_next = (b == jcws_pkg::CH_STAR) ? jcws_pkg::MODE_BLOCK_STAR
                                                  : jcws_pkg::MODE_BLOCK;
      end
      jcws_pkg::MODE_BLOCK_STAR: begin
        if (b == jcws_pkg::CH_SLASH) scan_mode_next = jcws_pkg::MODE_NORMAL;
        else if (b == jcws_pkg::CH_STAR) scan_mode_next = jcws_pkg::MODE_BLOCK_STAR;
        else scan_mode_next = jcws_pkg::MODE_BLOCK;
      end
      jcws_pkg::MODE_STRING: begin
        if (b == jcws_pkg::CH_QUOTE) scan_mode_next = jcws_pkg::MODE_NORMAL;
        else if (b == jcws_pkg::CH_BSLASH) scan_mode_next = jcws_pkg::MODE_STRING_ESC;
        else scan_mode_next = jcws_pkg::MODE_STRING;
      end
      jcws_pkg::MODE_STRING_ESC: scan_mode_next = jcws_pkg::MODE_STRING;
      default: scan_mode_next = plain_mode;
    endcase
    if (in_data.in_last) scan_mode_next = jcws_pkg::MODE_NORMAL;
  end

  // Keep decision, kept apart from the next-state logic.
  always_comb begin
    unique case (scan_mode)
      jcws_pkg::MODE_SLASH: begin
        keep = (b == jcws_pkg::CH_SLASH || b == jcws_pkg::CH_STAR) ? 1'b0 : plain_keep;
      end
      jcws_pkg::MODE_LINE, jcws_pkg::MODE_BLOCK,
      jcws_pkg::MODE_BLOCK_STAR:                   keep = 1'b0;
      jcws_pkg::MODE_STRING,
      jcws_pkg::MODE_STRING_ESC:                   keep = 1'b1;
      default:                                     keep = plain_keep;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= jcws_pkg::MODE_NORMAL;
      out_valid <= 1'b0;
    end else begin
      if (accept) scan_mode <= scan_mode_next;
      if (accept) out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.out_byte   <= keep ? b : 8'h00;
      out_data.byte_valid <= keep;
      out_data.out_last   <= in_data.in_last;
    end
  end

  // A result always carries either a kept byte or the end mark.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_valid || out_data.out_last))
    else $error("result with neither byte nor end mark");

  // After the final byte the scanner is back in normal mode.
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.in_last) |=> scan_mode == jcws_pkg::MODE_NORMAL)
    else $error("scan mode not reset after last byte");

  // Dropped bytes report zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |-> out_data.out_byte == 8'h00)
    else $error("dropped byte not zeroed");

  // Inside a comment nothing is kept.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (scan_mode == jcws_pkg::MODE_LINE || scan_mode == jcws_pkg::MODE_BLOCK))
      |-> !keep)
    else $error("byte kept inside a comment");

endmodule

// File: tb/jcws_minify_checker.sv
// Checker for the JSON minifier: predicts each result item and compares it with the block's output.
module jcws_minify_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  jcws_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  jcws_pkg::out_item_t out_data,
  output int                  errors,
  output int                  pending
);

  jcws_pkg::out_item_t  minified_q[$];
  jcws_pkg::scan_mode_t track_mode;
  jcws_pkg::scan_mode_t nxt_mode;
  jcws_pkg::out_item_t  want;
  jcws_pkg::out_item_t  got;
  int                   mismatches = 0;

  // Byte seen outside strings and comments; returns 1 when it is kept.
  function automatic logic outside_byte(input logic [7:0] b,
                                        output jcws_pkg::scan_mode_t nxt);
    nxt = jcws_pkg::MODE_NORMAL;
    if (b == jcws_pkg::CH_SPACE || b == jcws_pkg::CH_TAB ||
        b == jcws_pkg::CH_CR || b == jcws_pkg::CH_LF)
      return 1'b0;
    if (b == jcws_pkg::CH_SLASH) begin
      nxt = jcws_pkg::MODE_SLASH;
      return 1'b0;
    end
    if (b == jcws_pkg::CH_QUOTE)
      nxt = jcws_pkg::MODE_STRING;
    return 1'b1;
  endfunction

  // Returns 1 when the byte gives a result item.
  function automatic logic minify_byte(input jcws_pkg::scan_mode_t mode,
                                       input jcws_pkg::in_item_t item,
                                       output jcws_pkg::scan_mode_t nxt,
                                       output jcws_pkg::out_item_t res);
    logic [7:0] b;
    logic       keep;
    b    = item.in_byte;
    keep = 1'b0;
    nxt  = jcws_pkg::MODE_NORMAL;
    case (mode)
      jcws_pkg::MODE_SLASH: begin
        if (b == jcws_pkg::CH_SLASH)
          nxt = jcws_pkg::MODE_LINE;
        else if (b == jcws_pkg::CH_STAR)
          nxt = jcws_pkg::MODE_BLOCK;
        else
          keep = outside_byte(b, nxt);
      end
      jcws_pkg::MODE_LINE: begin
        if (b != jcws_pkg::CH_LF)
          nxt = jcws_pkg::MODE_LINE;
      end
      jcws_pkg::MODE_BLOCK: begin
        nxt = (b == jcws_pkg::CH_STAR) ? jcws_pkg::MODE_BLOCK_STAR : jcws_pkg::MODE_BLOCK;
      end
      jcws_pkg::MODE_BLOCK_STAR: begin
        if (b == jcws_pkg::CH_SLASH)
          nxt = jcws_pkg::MODE_NORMAL;
        else if (b == jcws_pkg::CH_STAR)
          nxt = jcws_pkg::MODE_BLOCK_STAR;
        else
          nxt = jcws_pkg::MODE_BLOCK;
      end
      jcws_pkg::MODE_STRING: begin
        keep = 1'b1;
        if (b == jcws_pkg::CH_QUOTE)
          nxt = jcws_pkg::MODE_NORMAL;
        else if (b == jcws_pkg::CH_BSLASH)
          nxt = jcws_pkg::MODE_STRING_ESC;
        else
          nxt = jcws_pkg::MODE_STRING;
      end
      jcws_pkg::MODE_STRING_ESC: begin
        keep = 1'b1;
        nxt  = jcws_pkg::MODE_STRING;
      end
      default: begin
        keep = outside_byte(b, nxt);
      end
    endcase
    // end of text abandons any open string, comment or pending slash
    if (item.in_last)
      nxt = jcws_pkg::MODE_NORMAL;
    res.out_byte   = keep ? b : 8'h00;
    res.byte_valid = keep;
    res.out_last   = item.in_last;
    return keep || item.in_last;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      minified_q.delete();
      track_mode = jcws_pkg::MODE_NORMAL;
    end else begin
      // compare before predicting: a result never stems from the item taken at this edge
      if (out_valid && out_ready) begin
        if (minified_q.size() == 0) begin
          $error("unexpected result item: out_byte %h byte_valid %b out_last %b",
                 out_data.out_byte, out_data.byte_valid, out_data.out_last);
          mismatches++;
        end else begin
          want = minified_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (out_data.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, actual %b", want.byte_valid, out_data.byte_valid);
            mismatches++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, out_data.out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (minify_byte(track_mode, in_data, nxt_mode, got))
          minified_q.push_back(got);
        track_mode = nxt_mode;
      end
    end
    errors  <= mismatches;
    pending <= minified_q.size();
  end

endmodule

// File: tb/json_comment_whitespace_stripper_top_tb.sv
// Testbench top for the JSON minifier: directed and random text, random idling, verdict.
module json_comment_whitespace_stripper_top_tb;

  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 400;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                out_ready = 1'b0;
  jcws_pkg::in_item_t  in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  jcws_pkg::out_item_t out_data;
  int                  errors;
  int                  pending;
  int                  sent   = 0;
  int                  cycles = 0;
  bit                  no_idle = 1'b0;
  logic [7:0]          text_q[$];

  json_comment_whitespace_stripper_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  jcws_minify_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    // switch between idle-free stretches and random gaps now and then
    if (sent % 50 == 0)
      no_idle = ($urandom_range(0, 2) == 0);
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  // Appends one JSON-like token, comment or stray byte to text_q.
  task automatic add_token();
    string punct;
    int    n;
    logic [7:0] b;
    punct = "{}[]:,-.0123456789eEtruefalsn";
    n     = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: begin
        for (int i = 0; i <= n; i++) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(jcws_pkg::CH_SPACE);
            1: text_q.push_back(jcws_pkg::CH_TAB);
            2: text_q.push_back(jcws_pkg::CH_CR);
            default: text_q.push_back(jcws_pkg::CH_LF);
          endcase
        end
      end
      1: begin
        text_q.push_back(jcws_pkg::CH_SLASH);
        text_q.push_back(jcws_pkg::CH_SLASH);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          text_q.push_back(b == jcws_pkg::CH_LF ? jcws_pkg::CH_STAR : b);
        end
        text_q.push_back(jcws_pkg::CH_LF);
      end
      2: begin
        text_q.push_back(jcws_pkg::CH_SLASH);
        text_q.push_back(jcws_pkg::CH_STAR);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(jcws_pkg::CH_STAR);
            1: text_q.push_back(jcws_pkg::CH_SLASH);
            default: text_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        text_q.push_back(jcws_pkg::CH_STAR);
        text_q.push_back(jcws_pkg::CH_SLASH);
      end
      3: begin
        text_q.push_back(jcws_pkg::CH_QUOTE);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(jcws_pkg::CH_BSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back((b == jcws_pkg::CH_QUOTE || b == jcws_pkg::CH_BSLASH) ? 8'h61 : b);
          end
        end
        text_q.push_back(jcws_pkg::CH_QUOTE);
      end
      4: begin
        text_q.push_back(jcws_pkg::CH_SLASH);
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      5: begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        for (int i = 0; i <= n % 3; i++)
          text_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
      end
    endcase
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (taken == 100)
        stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int goal;
    logic [7:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // whitespace, stray slash, both comment kinds, escapes in a string
    send_item(jcws_pkg::CH_SPACE, 1'b0);
    send_item(jcws_pkg::CH_TAB, 1'b0);
    send_item(jcws_pkg::CH_CR, 1'b0);
    send_item(jcws_pkg::CH_LF, 1'b0);
    send_text("/{");
    send_text("//\n");
    send_text("/***/");
    send_text("\"\\\"\\q \"");
    // zero byte kept; end mark on a dropped byte, on an opening quote, on 0xFF
    send_item(8'h00, 1'b0);
    send_item(jcws_pkg::CH_SPACE, 1'b1);
    send_item(jcws_pkg::CH_QUOTE, 1'b1);
    send_item(8'hFF, 1'b1);

    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      add_token();
      while (text_q.size() != 0) begin
        b = text_q.pop_front();
        send_item(b, $urandom_range(0, 39) == 0);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
